### rtl/core/led_matrix_scan_controller_defines.svh
// assertion macros for the led matrix scan controller
// used by rtl modules that check their own sequencing; no other dependencies
`ifndef LED_MATRIX_SCAN_CONTROLLER_DEFINES_SVH
`define LED_MATRIX_SCAN_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define LMSC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmsc assertion failed");
`define LMSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmsc assertion failed");
`else
`define LMSC_ASSERT_SAME(label, clk, rst, ante, cons)
`define LMSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/lmsc_pkg.sv
// shared types and constants for the led matrix scan controller
// no dependencies
`timescale 1ns / 1ps

package lmsc_pkg;

  localparam int CMD_W    = 3;
  localparam int DIGIT_W  = 4;
  localparam int LINE_W   = 3;
  localparam int COLUMN_W = 3;
  localparam int BYTE_W   = 8;
  localparam int PERIOD_W = 16;
  localparam int ELAPSED_W = 17;

  localparam logic [BYTE_W-1:0]    LINE_MASK    = 8'hFD;
  localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 16'd4000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 17'h1FFFF;
  localparam logic [LINE_W-1:0]    LINE_NONE    = 3'd7;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 3'd0,
    CMD_TOGGLE    = 3'd1,
    CMD_FILL      = 3'd2,
    CMD_APPLY     = 3'd3,
    CMD_CLEAR_ALL = 3'd4,
    CMD_APPLY_ALL = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_TOG_RD,
    ST_TOG_WR,
    ST_FILL,
    ST_CLEAR,
    ST_APPLY_CHK,
    ST_APPLY_RD,
    ST_APPLY_WR,
    ST_TICK_INC,
    ST_TICK_CMP,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic inc;
    logic sub;
  } period_ctl_t;

  function automatic logic [BYTE_W-1:0] line_bit(input logic [LINE_W-1:0] line);
    logic [BYTE_W-1:0] res;
    case (line)
      3'd0:    res = 8'h01;
      3'd1:    res = 8'h80;
      3'd2:    res = 8'h40;
      3'd3:    res = 8'h20;
      3'd4:    res = 8'h10;
      3'd5:    res = 8'h08;
      3'd6:    res = 8'h04;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

### rtl/core/lmsc_ifs.sv
// valid/ready channel interfaces: command, scan result and period write
// depends on lmsc_pkg
`timescale 1ns / 1ps

interface lmsc_req_if;
  import lmsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [DIGIT_W-1:0]  digit;
  logic [LINE_W-1:0]   line;
  logic [COLUMN_W-1:0] column;
  logic                fill_off;
  modport source (output valid, cmd, digit, line, column, fill_off, input ready);
  modport sink (input valid, cmd, digit, line, column, fill_off, output ready);
endinterface

interface lmsc_rsp_if;
  import lmsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [COLUMN_W-1:0] scan_column;
  logic [DIGIT_W-1:0]  scan_digit;
  logic [BYTE_W-1:0]   line_bits;
  logic                last;
  modport source (output valid, scan_column, scan_digit, line_bits, last, input ready);
  modport sink (input valid, scan_column, scan_digit, line_bits, last, output ready);
endinterface

interface lmsc_cfg_if;
  import lmsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] refresh_period;
  modport source (output valid, refresh_period, input ready);
  modport sink (input valid, refresh_period, output ready);
endinterface

### rtl/core/lmsc_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module lmsc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 60,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/lmsc_period.sv
// refresh period register and elapsed tick counter with compare and subtract
// depends on lmsc_pkg and lmsc_cfg_if
`timescale 1ns / 1ps

module lmsc_period (
  input  logic                 clk,
  input  logic                 rst,
  lmsc_cfg_if.sink             cfg,
  input  lmsc_pkg::period_ctl_t ctl,
  output logic                 due
);
  import lmsc_pkg::*;

  logic [PERIOD_W-1:0]  period;
  logic [ELAPSED_W-1:0] elapsed;
  logic [ELAPSED_W-1:0] period_ext;

  assign cfg.ready  = 1'b1;
  assign period_ext = ELAPSED_W'(period);
  assign due        = elapsed > period_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      period  <= PERIOD_RESET;
      elapsed <= '0;
    end else begin
      if (cfg.valid) begin
        period <= cfg.refresh_period;
      end
      if (ctl.inc && elapsed != ELAPSED_MAX) begin
        elapsed <= elapsed + ELAPSED_W'(1);
      end else if (ctl.sub) begin
        elapsed <= elapsed - period_ext;
      end
    end
  end

endmodule

### rtl/core/led_matrix_scan_controller.sv
// led matrix scan controller: command sequencer over shadow and active rams
// after reset a clearing pass fills both rams at every address, ready stays low
// toggle reads then rewrites one shadow byte, fill writes all columns of one digit,
// clear all rewrites every shadow byte, apply only sets marks; tick copies marked
// digits to active, then if due sends one column, each byte held until taken
// synchronous active high reset clears control state and marks
`timescale 1ns / 1ps
`include "led_matrix_scan_controller_defines.svh"

module led_matrix_scan_controller #(
  parameter int DIGITS  = 12,
  parameter int COLUMNS = 5
) (
  input logic      clk,
  input logic      rst,
  lmsc_req_if.sink req,
  lmsc_rsp_if.source rsp,
  lmsc_cfg_if.sink cfg
);
  import lmsc_pkg::*;

  localparam int DW    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int DEPTH = DIGITS * COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state, state_next;

  logic [DW-1:0]     dig_cnt;
  logic [CW-1:0]     col_cnt;
  logic [CW-1:0]     cur_col;
  logic [DIGITS-1:0] pending;
  logic [LINE_W-1:0] line_sel;
  logic [BYTE_W-1:0] fill_val;
  logic              rsp_valid;

  logic [AW-1:0]     addr;
  logic              dig_last, col_last;
  logic              xfer, rsp_xfer;
  logic              tog_ok, dig_ok;
  logic              sh_we, sh_re, act_we, act_re;
  logic [BYTE_W-1:0] sh_wdata, act_wdata, sh_rdata, act_rdata;
  period_ctl_t       pctl;
  logic              due;

  assign dig_last = dig_cnt == DW'(DIGITS - 1);
  assign col_last = col_cnt == CW'(COLUMNS - 1);
  assign addr     = AW'(AW'(dig_cnt) * AW'(COLUMNS) + AW'(col_cnt));
  assign xfer     = req.valid && req.ready;
  assign rsp_xfer = rsp_valid && rsp.ready;
  assign dig_ok   = int'(req.digit) < DIGITS;
  assign tog_ok   = dig_ok && int'(req.column) < COLUMNS && req.line != LINE_NONE;
  assign rsp.valid = rsp_valid;

  lmsc_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_shadow (
    .clk   (clk),
    .we    (sh_we),
    .waddr (addr),
    .wdata (sh_wdata),
    .re    (sh_re),
    .raddr (addr),
    .rdata (sh_rdata)
  );

  lmsc_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_active (
    .clk   (clk),
    .we    (act_we),
    .waddr (addr),
    .wdata (act_wdata),
    .re    (act_re),
    .raddr (addr),
    .rdata (act_rdata)
  );

  lmsc_period u_period (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .ctl (pctl),
    .due (due)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT, ST_CLEAR: begin
        if (col_last && dig_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid) begin
          case (cmd_t'(req.cmd))
            CMD_TICK:      state_next = ST_APPLY_CHK;
            CMD_TOGGLE:    state_next = tog_ok ? ST_TOG_RD : ST_IDLE;
            CMD_FILL:      state_next = dig_ok ? ST_FILL : ST_IDLE;
            CMD_CLEAR_ALL: state_next = ST_CLEAR;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_TOG_RD:    state_next = ST_TOG_WR;
      ST_TOG_WR:    state_next = ST_IDLE;
      ST_FILL: begin
        if (col_last) state_next = ST_IDLE;
      end
      ST_APPLY_CHK: begin
        if (pending[dig_cnt]) state_next = ST_APPLY_RD;
        else if (dig_last)    state_next = ST_TICK_INC;
      end
      ST_APPLY_RD:  state_next = ST_APPLY_WR;
      ST_APPLY_WR: begin
        if (!col_last)     state_next = ST_APPLY_RD;
        else if (dig_last) state_next = ST_TICK_INC;
        else               state_next = ST_APPLY_CHK;
      end
      ST_TICK_INC:  state_next = ST_TICK_CMP;
      ST_TICK_CMP:  state_next = due ? ST_EMIT_RD : ST_IDLE;
      ST_EMIT_RD: begin
        if (!rsp_valid) state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD:   state_next = dig_last ? ST_IDLE : ST_EMIT_RD;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready = 1'b0;
    sh_we     = 1'b0;
    sh_re     = 1'b0;
    sh_wdata  = LINE_MASK;
    act_we    = 1'b0;
    act_re    = 1'b0;
    act_wdata = LINE_MASK;
    pctl      = '0;
    case (state)
      ST_INIT: begin
        sh_we  = 1'b1;
        act_we = 1'b1;
      end
      ST_IDLE:     req.ready = 1'b1;
      ST_CLEAR:    sh_we = 1'b1;
      ST_FILL: begin
        sh_we    = 1'b1;
        sh_wdata = fill_val;
      end
      ST_TOG_RD:   sh_re = 1'b1;
      ST_TOG_WR: begin
        sh_we    = 1'b1;
        sh_wdata = sh_rdata ^ line_bit(line_sel);
      end
      ST_APPLY_RD: sh_re = 1'b1;
      ST_APPLY_WR: begin
        act_we    = 1'b1;
        act_wdata = sh_rdata;
      end
      ST_TICK_INC: pctl.inc = 1'b1;
      ST_TICK_CMP: pctl.sub = due;
      ST_EMIT_RD:  act_re = !rsp_valid;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      dig_cnt <= '0;
      col_cnt <= '0;
      cur_col <= '0;
      pending <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_INIT, ST_CLEAR: begin
          if (col_last) begin
            col_cnt <= '0;
            dig_cnt <= dig_cnt + DW'(1);
          end else begin
            col_cnt <= col_cnt + CW'(1);
          end
        end
        ST_IDLE: begin
          if (xfer) begin
            line_sel <= req.line;
            fill_val <= req.fill_off ? LINE_MASK : '0;
            case (cmd_t'(req.cmd))
              CMD_TOGGLE: begin
                dig_cnt <= DW'(req.digit);
                col_cnt <= CW'(req.column);
              end
              CMD_FILL: begin
                dig_cnt <= DW'(req.digit);
                col_cnt <= '0;
              end
              CMD_APPLY: begin
                if (dig_ok) pending[DW'(req.digit)] <= 1'b1;
              end
              CMD_APPLY_ALL: pending <= '1;
              default: begin
                dig_cnt <= '0;
                col_cnt <= '0;
              end
            endcase
          end
        end
        ST_FILL:      col_cnt <= col_cnt + CW'(1);
        ST_APPLY_CHK: begin
          col_cnt <= '0;
          if (!pending[dig_cnt] && !dig_last) dig_cnt <= dig_cnt + DW'(1);
        end
        ST_APPLY_WR: begin
          if (col_last) begin
            col_cnt          <= '0;
            pending[dig_cnt] <= 1'b0;
            if (!dig_last) dig_cnt <= dig_cnt + DW'(1);
          end else begin
            col_cnt <= col_cnt + CW'(1);
          end
        end
        ST_TICK_CMP: begin
          dig_cnt <= '0;
          col_cnt <= cur_col;
        end
        ST_EMIT_LD: begin
          if (dig_last) begin
            cur_col <= (cur_col == CW'(COLUMNS - 1)) ? '0 : cur_col + CW'(1);
          end else begin
            dig_cnt <= dig_cnt + DW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_EMIT_LD) begin
      rsp_valid <= 1'b1;
    end else if (rsp_xfer) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT_LD) begin
      rsp.scan_column <= COLUMN_W'(col_cnt);
      rsp.scan_digit  <= DIGIT_W'(dig_cnt);
      rsp.line_bits   <= act_rdata & LINE_MASK;
      rsp.last        <= dig_last;
    end
  end

  `LMSC_ASSERT_SAME(a_load_slot_free, clk, rst, state == ST_EMIT_LD, !rsp_valid)
  `LMSC_ASSERT_NEXT(a_tick_starts_apply, clk, rst,
    xfer && req.cmd == CMD_TICK, state == ST_APPLY_CHK)
  `LMSC_ASSERT_NEXT(a_col_advances, clk, rst,
    state == ST_EMIT_LD && dig_last && COLUMNS > 1, cur_col != $past(cur_col))
  `LMSC_ASSERT_NEXT(a_apply_clears_mark, clk, rst,
    state == ST_APPLY_WR && col_last, pending[$past(dig_cnt)] == 1'b0)

endmodule

### verif/testbench.sv
// self-checking bench for led_matrix_scan_controller: command, scan and period channels
// predicts scan bytes from its own copy of the shadow/active stores; needs lmsc_pkg, lmsc_ifs
`timescale 1ns / 1ps

module testbench;
  import lmsc_pkg::*;

  localparam int DIGITS = 12;
  localparam int COLUMNS = 5;
  localparam int CLK_PERIOD = 12;
  localparam int SETTLE_CYCLES = 200;
  localparam longint LIMIT_CYCLES = 3_000_000;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [DIGIT_W-1:0]  digit;
    logic [LINE_W-1:0]   line;
    logic [COLUMN_W-1:0] column;
    logic                fill_off;
  } matrix_cmd_t;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [DIGIT_W-1:0]  digit;
    logic [BYTE_W-1:0]   line_bits;
    logic                last;
  } scan_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lmsc_req_if req_ch ();
  lmsc_rsp_if rsp_ch ();
  lmsc_cfg_if cfg_ch ();

  led_matrix_scan_controller #(
    .DIGITS(DIGITS),
    .COLUMNS(COLUMNS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  matrix_cmd_t pending_cmds[$];
  scan_byte_t  expected_scans[$];
  matrix_cmd_t offered;
  int queued_cnt = 0;
  int accepted_cnt = 0;
  int errors = 0;
  int send_gap = 0;
  int stall_left = 0;
  logic rsp_block = 1'b0;
  logic steady = 1'b0;

  logic [BYTE_W-1:0]    shadow_mem [DIGITS][COLUMNS];
  logic [BYTE_W-1:0]    active_mem [DIGITS][COLUMNS];
  logic                 apply_mark [DIGITS];
  logic [ELAPSED_W-1:0] elapsed;
  logic [COLUMN_W-1:0]  scan_col;
  logic [PERIOD_W-1:0]  period;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BYTE_W-1:0] pixel_mask(logic [LINE_W-1:0] ln);
    if (ln == 0) return 8'h01;
    return 8'h80 >> (ln - 1);
  endfunction

  function automatic void execute_cmd(matrix_cmd_t c);
    scan_byte_t s;
    case (c.cmd)
      CMD_TICK: begin
        for (int d = 0; d < DIGITS; d++) begin
          if (apply_mark[d]) begin
            for (int k = 0; k < COLUMNS; k++) active_mem[d][k] = shadow_mem[d][k];
            apply_mark[d] = 1'b0;
          end
        end
        if (elapsed < ELAPSED_MAX) elapsed++;
        if (elapsed > ELAPSED_W'(period)) begin
          elapsed -= ELAPSED_W'(period);
          if (scan_col >= COLUMNS) scan_col = '0;
          for (int d = 0; d < DIGITS; d++) begin
            s.column = scan_col;
            s.digit = DIGIT_W'(d);
            s.line_bits = active_mem[d][scan_col] & LINE_MASK;
            s.last = (d == DIGITS - 1);
            expected_scans.push_back(s);
          end
          scan_col = (int'(scan_col) + 1 >= COLUMNS) ? '0 : scan_col + COLUMN_W'(1);
        end
      end
      CMD_TOGGLE: begin
        if (c.digit < DIGITS && c.column < COLUMNS && c.line != LINE_NONE)
          shadow_mem[c.digit][c.column] ^= pixel_mask(c.line);
      end
      CMD_FILL: begin
        if (c.digit < DIGITS)
          for (int k = 0; k < COLUMNS; k++) shadow_mem[c.digit][k] = c.fill_off ? LINE_MASK : '0;
      end
      CMD_APPLY: begin
        if (c.digit < DIGITS) apply_mark[c.digit] = 1'b1;
      end
      CMD_CLEAR_ALL: begin
        for (int d = 0; d < DIGITS; d++)
          for (int k = 0; k < COLUMNS; k++) shadow_mem[d][k] = LINE_MASK;
      end
      CMD_APPLY_ALL: begin
        for (int d = 0; d < DIGITS; d++) apply_mark[d] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string f, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, f, want, got);
      errors++;
    end
  endfunction

  // command driver
  always @(posedge clk) begin
    logic busy;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      busy = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        execute_cmd(offered);
        accepted_cnt++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_cmds.size() > 0) begin
          offered = pending_cmds.pop_front();
          req_ch.cmd <= offered.cmd;
          req_ch.digit <= offered.digit;
          req_ch.line <= offered.line;
          req_ch.column <= offered.column;
          req_ch.fill_off <= offered.fill_off;
          busy = 1'b1;
          send_gap = steady ? 0 : idle_len();
        end
      end
      req_ch.valid <= busy;
    end
  end

  // scan monitor and checker
  always @(posedge clk) begin
    scan_byte_t got;
    scan_byte_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = {rsp_ch.scan_column, rsp_ch.scan_digit, rsp_ch.line_bits, rsp_ch.last};
        if (expected_scans.size() == 0) begin
          $display("%0t ns: unexpected scan transfer, expected none, got %h", $time, got);
          errors++;
        end else begin
          want = expected_scans.pop_front();
          check_field("scan_column", 8'(want.column), 8'(got.column));
          check_field("scan_digit", 8'(want.digit), 8'(got.digit));
          check_field("line_bits", want.line_bits, got.line_bits);
          check_field("last", 8'(want.last), 8'(got.last));
        end
      end
      if (rsp_block) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!steady && $urandom_range(0, 2) == 0) stall_left = idle_len();
      end
    end
  end

  task automatic push_cmd(input logic [CMD_W-1:0] c, input int dg, input int ln,
                          input int cl, input int off);
    matrix_cmd_t m;
    m.cmd = c;
    m.digit = DIGIT_W'(dg);
    m.line = LINE_W'(ln);
    m.column = COLUMN_W'(cl);
    m.fill_off = 1'(off);
    pending_cmds.push_back(m);
    queued_cnt++;
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_cmd(CMD_TICK, $urandom_range(0, 15), $urandom_range(0, 7),
                        $urandom_range(0, 7), $urandom_range(0, 1));
  endtask

  task automatic settle();
    while (accepted_cnt != queued_cnt || expected_scans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.refresh_period <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    period = v;
  endtask

  task automatic queue_random(input int n);
    int start;
    int r;
    start = queued_cnt;
    while (queued_cnt - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        push_cmd(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 15), $urandom_range(0, 7),
                 $urandom_range(0, 7), $urandom_range(0, 1));
      end else if (r < 60) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 4) == 0)
            push_cmd(CMD_FILL, $urandom_range(0, DIGITS - 1), $urandom_range(0, 7),
                     $urandom_range(0, 7), $urandom_range(0, 1));
          else
            push_cmd(CMD_TOGGLE, $urandom_range(0, DIGITS - 1), $urandom_range(0, 6),
                     $urandom_range(0, COLUMNS - 1), $urandom_range(0, 1));
        end
        r = $urandom_range(0, 9);
        if (r < 5) push_cmd(CMD_APPLY, $urandom_range(0, DIGITS - 1), 0, 0, 0);
        else if (r < 9) push_cmd(CMD_APPLY_ALL, 0, 0, 0, 0);
        else push_cmd(CMD_CLEAR_ALL, 0, 0, 0, 0);
        push_ticks($urandom_range(1, 4));
      end else begin
        push_ticks($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    int phase_period [6];
    phase_period = '{1, 3, 2, 1, 4, 2};
    req_ch.valid = 1'b0;
    req_ch.cmd = '0;
    req_ch.digit = '0;
    req_ch.line = '0;
    req_ch.column = '0;
    req_ch.fill_off = 1'b0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.refresh_period = '0;
    for (int d = 0; d < DIGITS; d++) begin
      apply_mark[d] = 1'b0;
      for (int k = 0; k < COLUMNS; k++) begin
        shadow_mem[d][k] = LINE_MASK;
        active_mem[d][k] = LINE_MASK;
      end
    end
    elapsed = '0;
    scan_col = '0;
    period = PERIOD_RESET;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset contents, pixel map ends, ignored edits, fills, applies, spare codes
    write_period(1);
    push_cmd(CMD_APPLY_ALL, 0, 0, 0, 0);
    push_ticks(2);
    push_cmd(CMD_TOGGLE, 0, 0, 0, 0);
    push_cmd(CMD_TOGGLE, 11, 6, 4, 1);
    push_cmd(CMD_TOGGLE, 5, 3, 1, 0);
    push_cmd(CMD_TOGGLE, 1, LINE_NONE, 1, 0);
    push_cmd(CMD_TOGGLE, 12, 2, 0, 0);
    push_cmd(CMD_TOGGLE, 15, 1, 0, 1);
    push_cmd(CMD_TOGGLE, 2, 1, 5, 0);
    push_cmd(CMD_TOGGLE, 2, 5, 7, 0);
    push_cmd(CMD_FILL, 3, 7, 7, 0);
    push_cmd(CMD_FILL, 15, 0, 0, 0);
    push_cmd(CMD_FILL, 7, 0, 0, 1);
    push_cmd(CMD_APPLY, 0, 0, 0, 0);
    push_cmd(CMD_APPLY, 15, 0, 0, 0);
    push_cmd(CMD_APPLY, 11, 0, 0, 0);
    push_cmd(CMD_SPARE_6, 3, 3, 3, 1);
    push_cmd(CMD_SPARE_7, 15, 7, 7, 1);
    push_ticks(1);
    push_cmd(CMD_APPLY_ALL, 0, 0, 0, 0);
    push_ticks(5);
    push_cmd(CMD_CLEAR_ALL, 0, 0, 0, 0);
    push_cmd(CMD_APPLY_ALL, 0, 0, 0, 0);
    push_ticks(1);
    settle();

    // zero period: every tick scans a column
    write_period(0);
    push_cmd(CMD_FILL, 4, 0, 0, 0);
    push_cmd(CMD_APPLY, 4, 0, 0, 0);
    push_ticks(6);
    settle();

    // longest period, then lowered below the elapsed count
    write_period(16'hFFFF);
    push_ticks(30);
    push_cmd(CMD_FILL, 9, 0, 0, 0);
    push_cmd(CMD_APPLY_ALL, 0, 0, 0, 0);
    push_ticks(30);
    settle();
    write_period(2);
    push_ticks(15);
    settle();

    for (int p = 0; p < 6; p++) begin
      write_period(phase_period[p]);
      steady <= (p == 3);
      queue_random(26);
      if (p == 0) begin
        // scan side held off while commands keep coming
        rsp_block <= 1'b1;
        repeat (400) @(posedge clk);
        rsp_block <= 1'b0;
      end
      settle();
    end
    steady <= 1'b0;

    if (errors == 0 && expected_scans.size() == 0)
      $display("PASS led_matrix_scan_controller");
    else
      $display("FAIL led_matrix_scan_controller");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAIL led_matrix_scan_controller");
    $finish;
  end

endmodule
